>>> hw/rtl/kts_pkg.sv
// Shared types and constants for the keyframe track sampler.
package kts_pkg;

    localparam int MAX_PARTS_DEF      = 16;
    localparam int KEYS_PER_TRACK_DEF = 64;
    localparam int NUM_TRACKS         = 4;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_TEX    = 2'd1;
    localparam logic [1:0] FUNC_APPEND = 2'd2;
    localparam logic [1:0] FUNC_SAMPLE = 2'd3;

    localparam int KEY_WIDTH = 4 + 32 + 32;

    typedef struct packed {
        logic [3:0]  part;
        logic [31:0] ktime;
        logic [31:0] kval;
    } key_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] ts;
        logic [31:0] vs;
        logic [31:0] te;
        logic [31:0] ve;
        logic [31:0] t;
    } interp_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } interp_rsp_t;

endpackage

>>> hw/rtl/kts_ram.sv
// Generic single-port RAM with registered read.
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/kts_interp.sv
// Serial interpolation unit: shift-add multiply, restoring divide, saturating add.
module kts_interp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kts_pkg::interp_req_t req,
    output kts_pkg::interp_rsp_t rsp
);

    localparam logic [1:0] I_IDLE = 2'd0;
    localparam logic [1:0] I_MUL  = 2'd1;
    localparam logic [1:0] I_DIV  = 2'd2;
    localparam logic [1:0] I_FIN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [31:0] vs_reg, vs_next;
    logic [63:0] acc_reg, acc_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic signed [32:0] dv;
    logic [32:0]        rem_sh;
    logic [33:0]        diff;
    logic signed [34:0] sum;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        vs_next    = vs_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        dv         = $signed({req.ve[31], req.ve}) - $signed({req.vs[31], req.vs});
        rem_sh     = {rem_reg[31:0], acc_reg[63]};
        diff       = {1'b0, rem_sh} - {2'b00, den_reg};
        sum        = neg_reg ? $signed({{3{vs_reg[31]}}, vs_reg}) - $signed({2'b00, acc_reg[32:0]})
                             : $signed({{3{vs_reg[31]}}, vs_reg}) + $signed({2'b00, acc_reg[32:0]});
        unique case (state_reg)
            I_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = req.t - req.ts;
                    den_next   = req.te - req.ts;
                    neg_next   = dv[32];
                    mag_next   = dv[32] ? 32'(-dv) : dv[31:0];
                    vs_next    = req.vs;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = I_MUL;
                end
            end
            I_MUL:
            begin
                acc_next = {acc_reg[62:0], 1'b0} + (num_reg[31] ? {32'd0, mag_reg} : 64'd0);
                num_next = {num_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = I_DIV;
                end
            end
            I_DIV:
            begin
                rem_next = diff[33] ? rem_sh : diff[32:0];
                acc_next = {acc_reg[62:0], ~diff[33]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = I_FIN;
                end
            end
            I_FIN:
            begin
                // quotient is below the value span, saturation kept as a guard
                if (sum > 35'sd2147483647)
                begin
                    res_next = 32'h7FFF_FFFF;
                end
                else if (sum < -35'sd2147483648)
                begin
                    res_next = 32'h8000_0000;
                end
                else
                begin
                    res_next = sum[31:0];
                end
                done_next  = 1'b1;
                state_next = I_IDLE;
            end
            default:
            begin
                state_next = I_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        vs_reg  <= vs_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

>>> hw/rtl/keyframe_track_sampler.sv
// Keyframe track sampler: part textures, four keyframe tracks, linear sampling.
// Clear, texture set and append complete when they are accepted.
// A sample visits each valid part; for each track it scans the key RAM, then runs the serial
// multiply/divide unit if that track matched; parts that are not valid are skipped.
// One result word per valid part; the next item is taken once the last result is loaded.
// Reset empties all parts and tracks and clears the overflow flag; RAM contents are kept.
module keyframe_track_sampler #(
    parameter int MAX_PARTS      = kts_pkg::MAX_PARTS_DEF,
    parameter int KEYS_PER_TRACK = kts_pkg::KEYS_PER_TRACK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  part,
    input  logic [1:0]  channel,
    input  logic [31:0] time_ticks,
    input  logic signed [31:0] key_value,
    input  logic [15:0] tex,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  part_index,
    output logic [15:0] frame_tex,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] scale_out,
    output logic signed [31:0] rotation,
    output logic        overflow,
    output logic        last
);

    localparam int PW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW  = $clog2(MAX_PARTS + 1);
    localparam int LW  = $clog2(KEYS_PER_TRACK + 1);
    localparam int KD  = kts_pkg::NUM_TRACKS * KEYS_PER_TRACK;
    localparam int KAW = $clog2(KD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [MAX_PARTS-1:0] pvalid_reg, pvalid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        emit_reg, emit_next;
    logic [LW-1:0]        len_reg [kts_pkg::NUM_TRACKS];
    logic [LW-1:0]        len_next [kts_pkg::NUM_TRACKS];
    logic                 ovf_reg, ovf_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [1:0]           ch_reg, ch_next;
    logic [LW-1:0]        issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 matched_reg, matched_next;
    logic                 start_reg, start_next;
    logic [31:0]          t_reg, t_next;
    kts_pkg::key_entry_t  prev_reg, prev_next;
    kts_pkg::key_entry_t  ma_reg, ma_next;
    kts_pkg::key_entry_t  mb_reg, mb_next;
    logic [31:0]          res_reg [kts_pkg::NUM_TRACKS];
    logic [31:0]          res_next [kts_pkg::NUM_TRACKS];
    logic                 ov_reg, ov_next;
    logic                 olast_reg, olast_next;
    logic                 oovf_reg, oovf_next;
    logic [3:0]           opart_reg, opart_next;
    logic [15:0]          otex_reg, otex_next;
    logic [31:0]          ores_reg [kts_pkg::NUM_TRACKS];
    logic [31:0]          ores_next [kts_pkg::NUM_TRACKS];

    logic                 accept;
    logic                 key_we;
    logic [KAW-1:0]       key_addr;
    kts_pkg::key_entry_t  key_wdata;
    kts_pkg::key_entry_t  key_rdata;
    logic                 tex_we;
    logic [PW-1:0]        tex_addr;
    logic [15:0]          tex_rdata;
    logic                 issue_ok;
    logic                 cur_match;
    logic                 advance;
    logic [31:0]          adv_value;
    kts_pkg::interp_req_t ireq;
    kts_pkg::interp_rsp_t irsp;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign issue_ok = (issue_reg < len_reg[ch_reg]);
    assign cur_match = have_prev_reg
                       && (32'(prev_reg.part) == 32'(p_reg))
                       && (32'(key_rdata.part) == 32'(p_reg))
                       && (prev_reg.ktime <= t_reg)
                       && (key_rdata.ktime > t_reg);

    always_comb
    begin
        key_we    = 1'b0;
        tex_we    = 1'b0;
        key_wdata = '{part: part, ktime: time_ticks, kval: key_value};
        tex_addr  = (state_reg == S_IDLE) ? PW'(part) : p_reg;
        if (state_reg == S_IDLE)
        begin
            key_addr = KAW'(channel) * KAW'(KEYS_PER_TRACK) + KAW'(len_reg[channel]);
        end
        else
        begin
            key_addr = KAW'(ch_reg) * KAW'(KEYS_PER_TRACK) + KAW'(issue_reg);
        end
        if (accept && func == kts_pkg::FUNC_APPEND && 32'(len_reg[channel]) < KEYS_PER_TRACK)
        begin
            key_we = 1'b1;
        end
        if (accept && func == kts_pkg::FUNC_TEX && 32'(part) < MAX_PARTS)
        begin
            tex_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pvalid_next    = pvalid_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        ch_next        = ch_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        have_prev_next = have_prev_reg;
        matched_next   = matched_reg;
        start_next     = 1'b0;
        t_next         = t_reg;
        prev_next      = prev_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        res_next       = res_reg;
        ov_next        = ov_reg;
        olast_next     = olast_reg;
        oovf_next      = oovf_reg;
        opart_next     = opart_reg;
        otex_next      = otex_reg;
        ores_next      = ores_reg;
        advance        = 1'b0;
        adv_value      = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        kts_pkg::FUNC_CLEAR:
                        begin
                            pvalid_next = '0;
                            count_next  = '0;
                            for (int i = 0; i < kts_pkg::NUM_TRACKS; i++)
                            begin
                                len_next[i] = '0;
                            end
                            ovf_next = 1'b0;
                        end
                        kts_pkg::FUNC_TEX:
                        begin
                            if (32'(part) < MAX_PARTS && !pvalid_reg[PW'(part)])
                            begin
                                pvalid_next[PW'(part)] = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        kts_pkg::FUNC_APPEND:
                        begin
                            if (32'(len_reg[channel]) < KEYS_PER_TRACK)
                            begin
                                len_next[channel] = len_reg[channel] + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        kts_pkg::FUNC_SAMPLE:
                        begin
                            if (count_reg != '0)
                            begin
                                t_next     = time_ticks;
                                p_next     = '0;
                                emit_next  = '0;
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (pvalid_reg[p_reg])
                begin
                    ch_next        = '0;
                    issue_next     = '0;
                    pend_next      = 1'b0;
                    have_prev_next = 1'b0;
                    matched_next   = 1'b0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end
            S_SCAN:
            begin
                pend_next = issue_ok;
                if (issue_ok)
                begin
                    issue_next = issue_reg + LW'(1);
                end
                if (pend_reg)
                begin
                    // the pair is (previous word, this word); later matches overwrite
                    if (cur_match)
                    begin
                        ma_next      = prev_reg;
                        mb_next      = key_rdata;
                        matched_next = 1'b1;
                    end
                    prev_next      = key_rdata;
                    have_prev_next = 1'b1;
                end
                if (!issue_ok && !pend_reg)
                begin
                    if (matched_reg)
                    begin
                        start_next = 1'b1;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end
            S_CALC:
            begin
                if (irsp.done)
                begin
                    advance   = 1'b1;
                    adv_value = irsp.value;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    olast_next = (CW'(emit_reg + CW'(1)) == count_reg);
                    oovf_next  = ovf_reg;
                    opart_next = 4'(p_reg);
                    otex_next  = tex_rdata;
                    ores_next  = res_reg;
                    emit_next  = emit_reg + CW'(1);
                    if (CW'(emit_reg + CW'(1)) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + PW'(1);
                        state_next = S_FIND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            res_next[ch_reg] = adv_value;
            issue_next       = '0;
            pend_next        = 1'b0;
            have_prev_next   = 1'b0;
            matched_next     = 1'b0;
            if (ch_reg == 2'd3)
            begin
                state_next = S_OUT;
            end
            else
            begin
                ch_next    = ch_reg + 2'd1;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pvalid_reg    <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            ovf_reg       <= 1'b0;
            p_reg         <= '0;
            ch_reg        <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            matched_reg   <= 1'b0;
            start_reg     <= 1'b0;
            ov_reg        <= 1'b0;
            for (int i = 0; i < kts_pkg::NUM_TRACKS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pvalid_reg    <= pvalid_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            ovf_reg       <= ovf_next;
            p_reg         <= p_next;
            ch_reg        <= ch_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            have_prev_reg <= have_prev_next;
            matched_reg   <= matched_next;
            start_reg     <= start_next;
            ov_reg        <= ov_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        prev_reg  <= prev_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        res_reg   <= res_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
        opart_reg <= opart_next;
        otex_reg  <= otex_next;
        ores_reg  <= ores_next;
    end

    assign ireq.start = start_reg;
    assign ireq.ts    = ma_reg.ktime;
    assign ireq.vs    = ma_reg.kval;
    assign ireq.te    = mb_reg.ktime;
    assign ireq.ve    = mb_reg.kval;
    assign ireq.t     = t_reg;

    kts_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .rsp   (irsp)
    );

    kts_ram #(
        .WIDTH (kts_pkg::KEY_WIDTH),
        .DEPTH (KD)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (key_wdata),
        .rdata (key_rdata)
    );

    kts_ram #(
        .WIDTH (16),
        .DEPTH (MAX_PARTS)
    ) u_tex_ram (
        .clk   (clk),
        .we    (tex_we),
        .addr  (tex_addr),
        .wdata (tex),
        .rdata (tex_rdata)
    );

    assign out_valid  = ov_reg;
    assign part_index = opart_reg;
    assign frame_tex  = otex_reg;
    assign pos_x      = ores_reg[0];
    assign pos_y      = ores_reg[1];
    assign scale_out  = ores_reg[2];
    assign rotation   = ores_reg[3];
    assign overflow   = oovf_reg;
    assign last       = olast_reg;

endmodule

>>> hw/rtl/kts_checker.sv
// Port-level checks for the keyframe track sampler, bound to the top level.
module kts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pos_x,
    input logic        overflow,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x))
        else $error("stalled result word changed");

    a_busy_mid_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken before a sample finished");

    a_ovf_per_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> overflow == $past(overflow))
        else $error("overflow changed within one sample");

    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a sample in progress");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .overflow  (overflow),
    .last      (last)
);

>>> test/keyframe_track_sampler_test.sv
// Self-checking testbench for the keyframe track sampler.
`timescale 1ns / 100ps

module keyframe_track_sampler_test;

    localparam int PARTS = kts_pkg::MAX_PARTS_DEF;
    localparam int KEYS  = kts_pkg::KEYS_PER_TRACK_DEF;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  part;
        logic [1:0]  channel;
        logic [31:0] time_ticks;
        logic [31:0] key_value;
        logic [15:0] tex;
    } cmd_t;

    typedef struct {
        logic [3:0]  part_index;
        logic [15:0] frame_tex;
        logic [31:0] chan_val [4];
        logic        overflow;
        logic        last;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [3:0]  part = '0;
    logic [1:0]  channel = '0;
    logic [31:0] time_ticks = '0;
    logic signed [31:0] key_value = '0;
    logic [15:0] tex = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  part_index;
    logic [15:0] frame_tex;
    logic signed [31:0] pos_x, pos_y, scale_out, rotation;
    logic        overflow, last;

    keyframe_track_sampler i_dut (.*);

    always #10 clk = ~clk;

    // predictor state
    logic [15:0] tex_of [PARTS];
    bit          part_on [PARTS];
    int          parts_on;
    logic [31:0] kt [4][KEYS];
    logic [31:0] kv [4][KEYS];
    logic [3:0]  kp [4][KEYS];
    int          track_len [4];
    bit          ovf;

    cmd_t   pending_cmds [$];
    frame_t expected_frames [$];
    int     fail_count = 0;
    bit     quiet = 0;
    bit     in_taken = 0;
    int     in_gap = 0, out_gap = 0;

    function automatic logic [31:0] lerp_key(logic [31:0] ts, logic [31:0] vs,
                                             logic [31:0] te, logic [31:0] ve,
                                             logic [31:0] t);
        longint s, dv, r;
        longint unsigned num, den, mag, q;
        s   = longint'($signed(vs));
        dv  = longint'($signed(ve)) - s;
        num = 64'(t - ts);
        den = 64'(te - ts);
        mag = (dv < 0) ? longint'(-dv) : dv;
        if (den == 0)
            return vs;
        q = (num * mag) / den;
        r = (dv < 0) ? s - longint'(q) : s + longint'(q);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic logic [31:0] track_value(int ch, int p, logic [31:0] t);
        logic [31:0] res;
        res = '0;
        for (int j = 0; j + 1 < track_len[ch]; j++)
            if (kp[ch][j] == p && kp[ch][j+1] == p && kt[ch][j] <= t && kt[ch][j+1] > t)
                res = lerp_key(kt[ch][j], kv[ch][j], kt[ch][j+1], kv[ch][j+1], t);
        return res;
    endfunction

    task automatic predict_frames(cmd_t c);
        frame_t f;
        int n;
        case (c.func)
            kts_pkg::FUNC_CLEAR:
            begin
                for (int p = 0; p < PARTS; p++)
                    part_on[p] = 0;
                parts_on = 0;
                for (int k = 0; k < 4; k++)
                    track_len[k] = 0;
                ovf = 0;
            end
            kts_pkg::FUNC_TEX:
            begin
                tex_of[c.part] = c.tex;
                if (!part_on[c.part])
                begin
                    part_on[c.part] = 1;
                    parts_on++;
                end
            end
            kts_pkg::FUNC_APPEND:
            begin
                if (track_len[c.channel] >= KEYS)
                    ovf = 1;
                else
                begin
                    kt[c.channel][track_len[c.channel]] = c.time_ticks;
                    kv[c.channel][track_len[c.channel]] = c.key_value;
                    kp[c.channel][track_len[c.channel]] = c.part;
                    track_len[c.channel]++;
                end
            end
            default:
            begin
                n = 0;
                for (int p = 0; p < PARTS; p++)
                begin
                    if (!part_on[p])
                        continue;
                    f.part_index = p[3:0];
                    f.frame_tex = tex_of[p];
                    for (int k = 0; k < 4; k++)
                        f.chan_val[k] = track_value(k, p, c.time_ticks);
                    f.overflow = ovf;
                    n++;
                    f.last = (n == parts_on);
                    expected_frames.insert(expected_frames.size(), f);
                end
            end
        endcase
    endtask

    task automatic queue_cmd(cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
        begin
            // stalled word stays on the bus
        end
        else if (in_gap > 0)
        begin
            in_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_cmds.size() == 0)
            in_valid <= 1'b0;
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            in_gap = $urandom_range(0, 2);
        end
        else
        begin
            in_valid   <= 1'b1;
            func       <= pending_cmds[0].func;
            part       <= pending_cmds[0].part;
            channel    <= pending_cmds[0].channel;
            time_ticks <= pending_cmds[0].time_ticks;
            key_value  <= pending_cmds[0].key_value;
            tex        <= pending_cmds[0].tex;
        end
        if (quiet)
            out_stall <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_gap = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor; input acceptance is taken here at the rising edge for the driver
    always @(posedge clk)
    begin
        frame_t e;
        logic [31:0] got [4];
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            predict_frames(pending_cmds.pop_front());
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pos_x, pos_y, scale_out, rotation};
            if (expected_frames.size() == 0)
            begin
                $display("%0t: expected no word, got part %0d", $realtime, part_index);
                fail_count++;
            end
            else
            begin
                e = expected_frames.pop_front();
                if (part_index !== e.part_index || frame_tex !== e.frame_tex
                    || overflow !== e.overflow || last !== e.last)
                begin
                    $display("%0t: expected part %0d tex %h ovf %b last %b, got %0d %h %b %b",
                             $realtime, e.part_index, e.frame_tex, e.overflow, e.last,
                             part_index, frame_tex, overflow, last);
                    fail_count++;
                end
                for (int k = 0; k < 4; k++)
                    if (got[k] !== e.chan_val[k])
                    begin
                        $display("%0t: part %0d channel %0d expected %h, got %h",
                                 $realtime, e.part_index, k, e.chan_val[k], got[k]);
                        fail_count++;
                    end
            end
        end
    end

    function automatic cmd_t make_cmd(logic [1:0] fn, int p, int ch,
                                      logic [31:0] t, logic [31:0] v, logic [15:0] tx);
        cmd_t c;
        c.func = fn;
        c.part = p[3:0];
        c.channel = ch[1:0];
        c.time_ticks = t;
        c.key_value = v;
        c.tex = tx;
        return c;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    initial
    begin
        int base_t, n_keys, n_parts, ch, p;
        parts_on = 0;
        ovf = 0;
        for (int k = 0; k < 4; k++)
            track_len[k] = 0;
        for (int q = 0; q < PARTS; q++)
            part_on[q] = 0;

        // directed: empty sample, extremes, mixed-part pairs, equal times
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_TEX, 0, 0, 0, 0, 16'h0000));
        queue_cmd(make_cmd(kts_pkg::FUNC_TEX, 15, 0, 0, 0, 16'hFFFF));
        queue_cmd(make_cmd(kts_pkg::FUNC_TEX, 15, 0, 0, 0, 16'hA5A5));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 0, 0, 0, 32'h8000_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 15, 1, 100, 32'h0001_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 0, 1, 200, 32'h0005_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 15, 2, 50, 32'hFFFF_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 15, 2, 50, 32'h0002_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 15, 3, 10, 32'h0001_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 15, 3, 30, 32'hFFFF_0000, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 32'hFFFF_FFFE, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 20, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 32'hFFFF_FFFF, 0, 0));
        // fill one track to overflow
        for (int j = 0; j < KEYS + 1; j++)
            queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, 0, 2, 1000 + 10 * j, $urandom, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 1005, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, 0, 0, 1005, 0, 0));

        // random scenes: a few parts, keys mostly ordered, most samples near keys
        for (int scene = 0; scene < 5; scene++)
        begin
            queue_cmd(make_cmd(kts_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom,
                               $urandom, $urandom));
            n_parts = $urandom_range(1, 4);
            for (int i = 0; i < n_parts; i++)
                queue_cmd(make_cmd(kts_pkg::FUNC_TEX, $urandom_range(0, 15), 0,
                                   $urandom, $urandom, $urandom));
            n_keys = $urandom_range(3, 10);
            base_t = $urandom_range(0, 1000);
            p = $urandom_range(0, 15);
            for (int i = 0; i < n_keys; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    p = $urandom_range(0, 15);
                ch = $urandom_range(0, 3);
                queue_cmd(make_cmd(kts_pkg::FUNC_APPEND, p, ch,
                    (scene == 4) ? $urandom : base_t + i * $urandom_range(1, 100),
                    rand_val(), $urandom));
            end
            for (int i = 0; i < 5; i++)
                queue_cmd(make_cmd(kts_pkg::FUNC_SAMPLE, $urandom, $urandom,
                    (i == 4) ? $urandom : base_t + $urandom_range(0, 600), $urandom, $urandom));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_cmds.size() < 40);
        quiet = 1;
        wait (pending_cmds.size() == 0 && !in_valid && expected_frames.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_frames.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

endmodule
